// ===== design/lpfp_pkg.sv =====
// Shared types and constants for the length-prefixed frame parser.
// No dependencies; imported by every module of the block.
package lpfp_pkg;

    localparam int START_LEN_DEF = 2;           // default start pattern length in bytes
    localparam int BYTE_W        = 8;
    localparam int CNT_W         = 32;          // byte counter, wide enough for any data length
    localparam int HLEN_W        = 8;
    localparam int DLEN_W        = 32;
    localparam int PAT_W         = 16;          // width of the start pattern register
    localparam int DLEN_BYTES    = DLEN_W / BYTE_W;

    typedef enum logic [2:0] {
        SEC_HUNT = 3'd0,
        SEC_HLEN = 3'd1,
        SEC_DLEN = 3'd2,
        SEC_HDR  = 3'd3,
        SEC_DATA = 3'd4,
        SEC_CSUM = 3'd5
    } lpfp_section_t;

    typedef enum logic [1:0] {
        KIND_HDR  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_GOOD = 2'd2,
        KIND_BAD  = 2'd3
    } lpfp_kind_t;

    typedef struct packed {
        logic [DLEN_W-1:0] data_length;
        logic [HLEN_W-1:0] header_length;
        logic [CNT_W-1:0]  offset;
        logic [BYTE_W-1:0] out_byte;
        lpfp_kind_t        kind;
        logic              frame_end;
    } lpfp_result_t;

endpackage

// ===== design/length_prefixed_frame_parser_unit.sv =====
// Top level of the length-prefixed frame parser with XOR checksum.
// Depends on lpfp_pkg, lpfp_parser and lpfp_out_buf.
//
//  Channel | Direction | Payload                                   | Handshake
//  --------+-----------+-------------------------------------------+-------------------
//  s_      | in        | tdata: rx_byte                            | tvalid / tready
//  m_      | out       | tdata, tuser: kind, tlast: frame_end      | tvalid / tready
//  cfg_    | in        | cfg_wr_data: start_pattern                | cfg_wr_en, no wait
//
//  One byte is accepted per cycle while s_tready is high; its result (if any)
//  is registered in the output register, via the skid entry while m_ stalls,
//  and shown on the m_ channel; the rate is set by the single parser state update.
//  Reset is synchronous and active low; it returns the parser to hunting and
//  clears the start pattern. A stalled m_ side is absorbed by one skid entry;
//  s_tready drops only once both the output register and the skid entry hold.
module length_prefixed_frame_parser_unit #(
    parameter int START_LEN = lpfp_pkg::START_LEN_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [lpfp_pkg::PAT_W-1:0]  cfg_wr_data,   // start_pattern, first byte in [15:8]
    // received bytes
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,       // [7:0] rx_byte
    // parser results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [79:0]                 m_tdata,       // [7:0] out_byte, [39:8] offset,
                                                       // [47:40] header_length,
                                                       // [79:48] data_length
    output logic [1:0]                  m_tuser,       // [1:0] kind
    output logic                        m_tlast        // frame_end
);
    import lpfp_pkg::*;

    logic         in_accept;
    logic         res_valid;
    lpfp_result_t res;
    lpfp_result_t out_res;

    // Take a byte whenever the skid stage has room.
    assign in_accept = s_tvalid && s_tready;

    lpfp_parser #(
        .START_LEN (START_LEN)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (in_accept),
        .in_byte     (s_tdata),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Hold results here until the downstream side takes the transaction.
    lpfp_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_valid),
        .push_data  (res),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_data   (out_res),
        .out_ready  (m_tready)
    );

    // Pack the payload, out_byte in the lowest bits and data_length in the highest.
    assign m_tdata = {out_res.data_length, out_res.header_length,
                      out_res.offset, out_res.out_byte};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.frame_end;

endmodule

// ===== design/lpfp_parser.sv =====
// Frame parser core: section state, byte counter, running XOR and lengths.
// Depends on lpfp_pkg; produces at most one result per accepted byte.
module lpfp_parser #(
    parameter int START_LEN = lpfp_pkg::START_LEN_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [lpfp_pkg::PAT_W-1:0]   cfg_wr_data,
    input  logic                         in_accept,
    input  logic [lpfp_pkg::BYTE_W-1:0]  in_byte,
    output logic                         res_valid,
    output lpfp_pkg::lpfp_result_t       res
);
    import lpfp_pkg::*;

    localparam int IDX_W = (START_LEN > 1) ? $clog2(START_LEN) : 1;

    lpfp_section_t     section_reg, section_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [HLEN_W-1:0] hdr_len_reg, hdr_len_next;
    logic [DLEN_W-1:0] data_len_reg, data_len_next;
    logic [PAT_W-1:0]  pattern_reg;

    logic [CNT_W-1:0]  count_inc;
    logic [IDX_W-1:0]  hunt_idx;
    logic [IDX_W:0]    pat_pos;
    logic [BYTE_W-1:0] expected_byte;
    logic [BYTE_W-1:0] xor_acc;

    assign count_inc = count_reg + CNT_W'(1);
    assign xor_acc   = xor_reg ^ in_byte;
    assign hunt_idx  = count_reg[IDX_W-1:0];
    assign pat_pos   = (IDX_W+1)'(START_LEN - 1) - {1'b0, hunt_idx};

    // Pattern bytes beyond the 16-bit register are expected to be zero.
    always_comb begin
        if (pat_pos == (IDX_W+1)'(0)) begin
            expected_byte = pattern_reg[BYTE_W-1:0];
        end else if (pat_pos == (IDX_W+1)'(1)) begin
            expected_byte = pattern_reg[2*BYTE_W-1:BYTE_W];
        end else begin
            expected_byte = '0;
        end
    end

    // Next state
    always_comb begin
        section_next  = section_reg;
        count_next    = count_reg;
        xor_next      = xor_reg;
        hdr_len_next  = hdr_len_reg;
        data_len_next = data_len_reg;
        if (in_accept) begin
            unique case (section_reg)
                SEC_HLEN: begin
                    xor_next      = xor_acc;
                    hdr_len_next  = in_byte;
                    data_len_next = '0;
                    count_next    = '0;
                    section_next  = SEC_DLEN;
                end
                SEC_DLEN: begin
                    xor_next      = xor_acc;
                    data_len_next = {data_len_reg[DLEN_W-BYTE_W-1:0], in_byte};
                    if (count_inc >= CNT_W'(DLEN_BYTES)) begin
                        count_next = '0;
                        if (hdr_len_reg != '0) begin
                            section_next = SEC_HDR;
                        end else if (data_len_next != '0) begin
                            section_next = SEC_DATA;
                        end else begin
                            section_next = SEC_CSUM;
                        end
                    end else begin
                        count_next = count_inc;
                    end
                end
                SEC_HDR: begin
                    xor_next = xor_acc;
                    if (count_inc >= {{(CNT_W-HLEN_W){1'b0}}, hdr_len_reg}) begin
                        count_next   = '0;
                        section_next = (data_len_reg != '0) ? SEC_DATA : SEC_CSUM;
                    end else begin
                        count_next = count_inc;
                    end
                end
                SEC_DATA: begin
                    xor_next = xor_acc;
                    if (count_inc >= data_len_reg) begin
                        count_next   = '0;
                        section_next = SEC_CSUM;
                    end else begin
                        count_next = count_inc;
                    end
                end
                SEC_CSUM: begin
                    section_next = SEC_HUNT;
                    count_next   = '0;
                    xor_next     = '0;
                end
                default: begin
                    // Hunt: a mismatching byte restarts the search without retrying it.
                    section_next = SEC_HUNT;
                    if (in_byte == expected_byte) begin
                        xor_next = xor_acc;
                        if (count_inc >= CNT_W'(START_LEN)) begin
                            count_next   = '0;
                            section_next = SEC_HLEN;
                        end else begin
                            count_next = count_inc;
                        end
                    end else begin
                        count_next = '0;
                        xor_next   = '0;
                    end
                end
            endcase
        end
    end

    // Result for the byte being accepted
    always_comb begin
        res_valid         = 1'b0;
        res.data_length   = data_len_reg;
        res.header_length = hdr_len_reg;
        res.offset        = count_reg;
        res.out_byte      = in_byte;
        res.kind          = KIND_HDR;
        res.frame_end     = 1'b0;
        unique case (section_reg)
            SEC_HDR: begin
                res_valid = in_accept;
            end
            SEC_DATA: begin
                res_valid = in_accept;
                res.kind  = KIND_DATA;
            end
            SEC_CSUM: begin
                res_valid     = in_accept;
                res.offset    = '0;
                res.out_byte  = '0;
                res.kind      = (xor_reg == in_byte) ? KIND_GOOD : KIND_BAD;
                res.frame_end = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            section_reg  <= SEC_HUNT;
            count_reg    <= '0;
            xor_reg      <= '0;
            hdr_len_reg  <= '0;
            data_len_reg <= '0;
            pattern_reg  <= '0;
        end else begin
            section_reg  <= section_next;
            count_reg    <= count_next;
            xor_reg      <= xor_next;
            hdr_len_reg  <= hdr_len_next;
            data_len_reg <= data_len_next;
            if (cfg_wr_en) begin
                pattern_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// ===== design/lpfp_out_buf.sv =====
// Output register with a skid stage for parser results.
// Depends on lpfp_pkg for the result structure.
module lpfp_out_buf (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  lpfp_pkg::lpfp_result_t  push_data,
    output logic                    push_ready,
    output logic                    out_valid,
    output lpfp_pkg::lpfp_result_t  out_data,
    input  logic                    out_ready
);
    import lpfp_pkg::*;

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    lpfp_result_t main_reg, main_next;
    lpfp_result_t skid_reg, skid_next;
    logic         pop;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop) begin
            // Refill the main register, oldest transaction first.
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end else if (push) begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for length_prefixed_frame_parser_unit: framed, broken and noisy
// byte streams under random back-pressure, every result transaction checked field by field.
// Depends on lpfp_pkg and the parser RTL only.
module testbench;
    import lpfp_pkg::*;

    localparam int PAT_BYTES   = START_LEN_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_GAP   = 4;      // output register plus skid entry, with margin
    localparam int MAX_REPORTS = 100;    // keep a badly broken run from flooding the log

    // Reset pattern 0x0000: one header byte, one data byte, correct checksum.
    // Carries both byte extremes through the pass-through path.
    localparam logic [7:0] OPEN_FRAME [10] = '{
        8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'hFF
    };
    // Pattern 0x55AA: a repeated first byte must not be retried as a new start,
    // then a frame with empty header and empty data and a wrong checksum.
    localparam logic [7:0] RESYNC_FRAME [11] = '{
        8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h33
    };

    // Tracks the parser state, predicts each result and checks the outputs in order.
    class frame_parse_checker;
        logic [PAT_W-1:0]  pattern;
        lpfp_section_t     section;
        logic [CNT_W-1:0]  count;
        logic [BYTE_W-1:0] xor_acc;
        logic [HLEN_W-1:0] hdr_len;
        logic [DLEN_W-1:0] data_len;
        lpfp_result_t      pending_items[$];
        int unsigned       errors;

        function new();
            pattern  = '0;
            section  = SEC_HUNT;
            count    = '0;
            xor_acc  = '0;
            hdr_len  = '0;
            data_len = '0;
            errors   = 0;
        endfunction

        // Start byte expected at position idx; positions above the register read as zero.
        function logic [7:0] pattern_byte(int unsigned idx);
            int unsigned pos;
            pos = PAT_BYTES - 1 - idx;
            if (pos >= 2)
                return 8'h00;
            return pattern[pos*8 +: 8];
        endfunction

        function void push_result(logic [7:0] b, lpfp_kind_t k, logic [31:0] off, logic fin);
            lpfp_result_t r;
            r.out_byte      = b;
            r.kind          = k;
            r.offset        = off;
            r.header_length = hdr_len;
            r.data_length   = data_len;
            r.frame_end     = fin;
            pending_items.push_back(r);
        endfunction

        function void leave_header();
            count   = '0;
            section = (data_len != 0) ? SEC_DATA : SEC_CSUM;
        endfunction

        function void take_rx_byte(logic [7:0] b);
            case (section)
                SEC_HLEN: begin
                    xor_acc ^= b;
                    hdr_len  = b;
                    data_len = '0;
                    count    = '0;
                    section  = SEC_DLEN;
                end
                SEC_DLEN: begin
                    xor_acc ^= b;
                    data_len = {data_len[DLEN_W-9:0], b};    // big-endian
                    count++;
                    if (count >= DLEN_BYTES) begin
                        count = '0;
                        if (hdr_len != 0)
                            section = SEC_HDR;
                        else
                            leave_header();
                    end
                end
                SEC_HDR: begin
                    xor_acc ^= b;
                    push_result(b, KIND_HDR, count, 1'b0);
                    count++;
                    if (count >= hdr_len)
                        leave_header();
                end
                SEC_DATA: begin
                    xor_acc ^= b;
                    push_result(b, KIND_DATA, count, 1'b0);
                    count++;
                    if (count >= data_len) begin
                        count   = '0;
                        section = SEC_CSUM;
                    end
                end
                SEC_CSUM: begin
                    push_result(8'h00, (xor_acc == b) ? KIND_GOOD : KIND_BAD, '0, 1'b1);
                    section = SEC_HUNT;
                    count   = '0;
                    xor_acc = '0;
                end
                default: begin
                    section = SEC_HUNT;
                    if (b == pattern_byte(count)) begin
                        xor_acc ^= b;
                        count++;
                        if (count >= PAT_BYTES) begin
                            count   = '0;
                            section = SEC_HLEN;
                        end
                    end else begin
                        count   = '0;
                        xor_acc = '0;
                    end
                end
            endcase
        endfunction

        function void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
            end
        endfunction

        function void match_output(logic [79:0] tdata, logic [1:0] tuser, logic tlast);
            lpfp_result_t want;
            if (pending_items.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("result transaction with none expected: tdata 0x%h kind %0d",
                           tdata, tuser);
                return;
            end
            want = pending_items.pop_front();
            check_field("out_byte", 32'(want.out_byte), 32'(tdata[7:0]));
            check_field("kind", 32'(want.kind), 32'(tuser));
            check_field("offset", want.offset, tdata[39:8]);
            check_field("header_length", 32'(want.header_length), 32'(tdata[47:40]));
            check_field("data_length", want.data_length, tdata[79:48]);
            check_field("frame_end", 32'(want.frame_end), 32'(tlast));
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [PAT_W-1:0]  cfg_wr_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [79:0]       m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    frame_parse_checker parse_check = new();
    bit                 steady_flow = 1'b0;   // high: neither side idles
    int unsigned        rx_count    = 0;
    int unsigned        cycle_count = 0;

    length_prefixed_frame_parser_unit #(
        .START_LEN (PAT_BYTES)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abandon the run if it hangs; the limit is many times the slowest legal run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: check each accepted transaction on the edge it completes, then
    // pick the next ready value. Values read here are those seen at the edge.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                parse_check.match_output(m_tdata, m_tuser, m_tlast);
            m_tready <= steady_flow || ($urandom_range(99) >= 38);
        end
    end

    // Offer one byte, idling at random beforehand, and hold it until accepted.
    task automatic send_byte(input logic [7:0] b);
        while (!steady_flow && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        parse_check.take_rx_byte(b);
        rx_count++;
    endtask

    // Break off a partial start match so the next byte is compared with the first one.
    task automatic clear_partial_match();
        while (parse_check.count != 0)
            send_byte(~parse_check.pattern_byte(parse_check.count));
    endtask

    // Drop valid and wait until every predicted result has been taken, plus the latency.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (parse_check.pending_items.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic load_pattern(input logic [PAT_W-1:0] p);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        parse_check.pattern = p;
    endtask

    // Send one frame with random header and data content. The checksum goes out only
    // when all dlen data bytes have been sent; bad_sum corrupts it.
    task automatic send_frame(input logic [7:0] hlen, input logic [31:0] dlen,
                              input int unsigned data_sent, input bit bad_sum);
        logic [7:0] fsum;
        logic [7:0] pb;
        fsum = 8'h00;
        clear_partial_match();
        for (int k = 0; k < PAT_BYTES; k++) begin
            pb = parse_check.pattern_byte(k);
            fsum ^= pb;
            send_byte(pb);
        end
        fsum ^= hlen;
        send_byte(hlen);
        for (int k = DLEN_BYTES - 1; k >= 0; k--) begin
            pb = dlen[k*8 +: 8];
            fsum ^= pb;
            send_byte(pb);
        end
        repeat (hlen + data_sent) begin
            pb = 8'($urandom);
            fsum ^= pb;
            send_byte(pb);
        end
        if (data_sent == dlen)
            send_byte(bad_sum ? fsum ^ 8'($urandom_range(1, 255)) : fsum);
    endtask

    // Mostly complete frames with small sections; the rest is noise on the hunting
    // state and starts that break off after the first pattern bytes.
    task automatic run_random_phase(input int unsigned upto);
        int unsigned roll;
        logic [7:0]  hlen;
        logic [31:0] dlen;
        logic [7:0]  pb;
        while (rx_count < upto) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                hlen = ($urandom_range(99) < 3) ? 8'd255 : 8'($urandom_range(0, 6));
                dlen = ($urandom_range(99) < 10) ? $urandom_range(13, 64)
                                                 : $urandom_range(0, 12);
                send_frame(hlen, dlen, dlen, $urandom_range(99) < 20);
            end else if (roll < 85) begin
                repeat ($urandom_range(1, 6)) begin
                    pb = 8'($urandom);
                    // never let noise complete the start pattern: random lengths would
                    // otherwise lock the parser in a huge data section
                    if (parse_check.count == PAT_BYTES - 1 &&
                        pb == parse_check.pattern_byte(PAT_BYTES - 1))
                        pb = ~pb;
                    send_byte(pb);
                end
            end else begin
                clear_partial_match();
                for (int k = 0; k < PAT_BYTES - 1; k++)
                    send_byte(parse_check.pattern_byte(k));
                send_byte(~parse_check.pattern_byte(PAT_BYTES - 1));
            end
        end
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset pattern first, then a written one
        foreach (OPEN_FRAME[i])
            send_byte(OPEN_FRAME[i]);
        load_pattern(16'h55AA);
        foreach (RESYNC_FRAME[i])
            send_byte(RESYNC_FRAME[i]);

        // random phases, each under its own start pattern
        load_pattern(16'hFFFF);
        run_random_phase(260);
        load_pattern(16'h0000);
        run_random_phase(500);
        load_pattern(16'($urandom));
        run_random_phase(740);
        steady_flow <= 1'b1;     // a long stretch at full rate on both sides
        load_pattern(16'($urandom));
        run_random_phase(980);
        steady_flow <= 1'b0;
        load_pattern(16'($urandom));
        run_random_phase(1220);

        // Data length at its maximum: the frame never closes, so send it last and
        // check only the leading data bytes.
        send_frame(8'd2, 32'hFFFF_FFFF, 40, 1'b0);
        drain_results();

        if (parse_check.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lpfp_pkg.sv
design/lpfp_parser.sv
design/lpfp_out_buf.sv
design/length_prefixed_frame_parser_unit.sv
test/testbench.sv
